### sv/bcdeq_pkg.sv
// ============================================================================
// bcdeq_pkg : shared types and constants of the button combo detector
// Item layouts, event record, register indexes and reset values.
// ============================================================================
package bcdeq_pkg;

    localparam int QUEUE_SIZE_DEF  = 16;
    localparam int NUM_BUTTONS_DEF = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_COMBO_HOLD    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_POLL = 1'd1;

    localparam logic [CFG_DATA_W-1:0] COMBO_HOLD_RST    = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] FALLBACK_POLL_RST = 16'd100;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STOP  = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [7:0]  port_bits;
        logic [31:0] time_ms;
        logic        irq_flag;
    } t_in_item;

    typedef struct packed {
        logic       sampled;
        logic [7:0] pressed_mask;
        logic       event_valid;
        logic       event_kind;
        logic [7:0] event_mask;
    } t_out_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] mask;
    } t_event;

    // request from the detector to the event ring
    typedef struct packed {
        logic   push;
        logic   pop;
        t_event ev;
    } t_ring_req;

    // status from the event ring
    typedef struct packed {
        logic   empty;
        t_event head;
    } t_ring_stat;

endpackage

### sv/button_combo_detector_event_queue.sv
// ============================================================================
// button_combo_detector_event_queue : multi-button combo detector
// Samples an active-low button port on interrupt or poll timeout, reports
// combo start and stop events through a ring that is read by pop items.
// ============================================================================
//
//  channel   valid        stall        payload      notes
//  -------   ----------   ----------   ----------   ---------------------------
//  in        i_in_valid   o_in_stall   i_in_item    tick or pop item
//  out       o_out_valid  i_out_stall  o_out_item   exactly one result per item
//  cfg       i_cfg_we     -            i_cfg_data   index i_cfg_idx, write only
//
//  One item per cycle while out does not stall; an accepted item is held in
//  the input register and then loaded into the result register, which drives out.
//  Reset is synchronous and active low; it clears all state and the ring
//  indexes and loads the register reset values. Ring entries are not cleared.
//  A stalled result holds in the result register; the input register keeps
//  its item and the input side stalls only when both are full and out stalls.
//
module button_combo_detector_event_queue
    import bcdeq_pkg::*;
#(
    parameter int QUEUE_SIZE  = QUEUE_SIZE_DEF,
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // buttons beyond NUM_BUTTONS are ignored
    localparam logic [7:0] BTN_BITS = 8'((1 << NUM_BUTTONS) - 1);

    // configuration registers
    logic [CFG_DATA_W-1:0] r_combo_hold;
    logic [CFG_DATA_W-1:0] r_fallback_poll;

    // pipeline registers
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    // detector state
    logic [31:0] r_last_sample;
    logic        r_cand_pending;
    logic [31:0] r_cand_start;
    logic        r_combo_active;
    logic [7:0]  r_combo_buttons;
    logic [7:0]  r_held_mask;

    logic        advance;
    logic        fire;
    logic        is_tick;
    logic        do_sample;
    logic [31:0] since_sample;
    logic [31:0] since_cand;
    logic [7:0]  mask;
    logic        multi;
    logic        start_ev;
    logic        stop_ev;
    t_ring_req   ring_req;
    t_ring_stat  ring_stat;
    t_out_item   result;

    // --- configuration port ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_combo_hold    <= COMBO_HOLD_RST;
            r_fallback_poll <= FALLBACK_POLL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COMBO_HOLD:    r_combo_hold    <= i_cfg_data;
                CFG_FALLBACK_POLL: r_fallback_poll <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // --- handshake: advance when the result register is free or drains ---
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // --- sample decision and combo tracking ---
    // time differences wrap modulo 2^32
    assign is_tick      = (r_in.operation == OP_TICK);
    assign since_sample = r_in.time_ms - r_last_sample;
    assign since_cand   = r_in.time_ms - r_cand_start;
    assign do_sample    = is_tick &&
                          (r_in.irq_flag || (since_sample >= 32'(r_fallback_poll)));
    assign mask         = ~r_in.port_bits & BTN_BITS;
    // two or more bits set: clearing the lowest set bit leaves something
    assign multi        = (mask & (mask - 8'd1)) != 8'd0;
    assign start_ev     = do_sample && multi && !r_combo_active && r_cand_pending &&
                          (since_cand >= 32'(r_combo_hold));
    assign stop_ev      = do_sample && !multi && r_combo_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_sample   <= '0;
            r_cand_pending  <= 1'b0;
            r_cand_start    <= '0;
            r_combo_active  <= 1'b0;
            r_combo_buttons <= '0;
            r_held_mask     <= '0;
        end else if (fire && do_sample) begin
            r_last_sample <= r_in.time_ms;
            r_held_mask   <= mask;
            if (multi) begin
                if (!r_combo_active) begin
                    if (!r_cand_pending) begin
                        // open a candidate hold
                        r_cand_pending <= 1'b1;
                        r_cand_start   <= r_in.time_ms;
                    end else if (start_ev) begin
                        r_cand_pending  <= 1'b0;
                        r_combo_active  <= 1'b1;
                        r_combo_buttons <= mask;
                    end
                end
            end else begin
                // fewer than two held: drop the candidate, close any combo
                r_cand_pending <= 1'b0;
                r_combo_active <= 1'b0;
            end
        end
    end

    // --- event ring ---
    always_comb begin
        ring_req.push    = fire && (start_ev || stop_ev);
        ring_req.pop     = fire && !is_tick;
        ring_req.ev.kind = start_ev ? KIND_START : KIND_STOP;
        ring_req.ev.mask = start_ev ? mask : r_combo_buttons;
    end

    bcdeq_ring #(
        .QUEUE_SIZE(QUEUE_SIZE)
    ) u_ring (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (ring_req),
        .o_stat (ring_stat)
    );

    // --- result ---
    always_comb begin
        result.sampled      = do_sample;
        result.pressed_mask = do_sample ? mask : r_held_mask;
        result.event_valid  = !is_tick && !ring_stat.empty;
        result.event_kind   = result.event_valid ? ring_stat.head.kind : 1'b0;
        result.event_mask   = result.event_valid ? ring_stat.head.mask : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### sv/bcdeq_ring.sv
// ============================================================================
// bcdeq_ring : event ring of the combo detector
// Circular store of events; drops a push when full, head read registered.
// ============================================================================
module bcdeq_ring
    import bcdeq_pkg::*;
#(
    parameter int QUEUE_SIZE = QUEUE_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ring_req  i_req,
    output t_ring_stat o_stat
);

    localparam int AW = $clog2(QUEUE_SIZE);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_SIZE - 1);

    t_event        r_mem [QUEUE_SIZE];
    t_event        r_head;
    logic [AW-1:0] r_wr_idx;
    logic [AW-1:0] r_rd_idx;
    logic [AW-1:0] n_wr_idx;
    logic [AW-1:0] n_rd_idx;
    logic [AW-1:0] wr_inc;
    logic [AW-1:0] rd_inc;
    logic          empty;
    logic          full;
    logic          push_ok;

    assign wr_inc  = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + AW'(1);
    assign rd_inc  = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + AW'(1);
    assign empty   = (r_rd_idx == r_wr_idx);
    assign full    = (wr_inc == r_rd_idx);
    assign push_ok = i_req.push && !full;

    always_comb begin
        n_wr_idx = push_ok ? wr_inc : r_wr_idx;
        n_rd_idx = (i_req.pop && !empty) ? rd_inc : r_rd_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
        end
    end

    // write port and registered head read; forward a write to the next head
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_idx] <= i_req.ev;
        end
        if (push_ok && (r_wr_idx == n_rd_idx)) begin
            r_head <= i_req.ev;
        end else begin
            r_head <= r_mem[n_rd_idx];
        end
    end

    assign o_stat.empty = empty;
    assign o_stat.head  = r_head;

endmodule
